// ----- src/dog_edge_threshold_11x11_assert.svh -----
// Assertion macros for the checker file of this block.
`ifndef DOG_EDGE_THRESHOLD_11X11_ASSERT_SVH
`define DOG_EDGE_THRESHOLD_11X11_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define DOG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must also hold while reset is applied.
`define DOG_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/dog_edge_pkg.sv -----
package dog_edge_pkg;

  localparam int WIN    = 11;
  localparam int LINES  = 10;
  localparam int HALF   = 5;
  localparam int QUAD   = 6;
  localparam int PIX_W  = 8;
  localparam int SUM_W  = 24;
  localparam int FOLD_W = 10;
  localparam int POS_W  = 9;
  localparam int SIZE_W = 10;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  // One quadrant of the kernel; the full 11x11 kernel mirrors it on both axes.
  localparam logic signed [9:0] KQ [QUAD][QUAD] = '{
    '{-10'sd1, -10'sd3,  -10'sd4,  -10'sd6,  -10'sd7,  -10'sd8},
    '{-10'sd3, -10'sd5,  -10'sd8,  -10'sd11, -10'sd13, -10'sd13},
    '{-10'sd4, -10'sd8,  -10'sd12, -10'sd16, -10'sd17, -10'sd17},
    '{-10'sd6, -10'sd11, -10'sd16, -10'sd16, 10'sd0,   10'sd15},
    '{-10'sd7, -10'sd13, -10'sd17, 10'sd0,   10'sd85,  10'sd160},
    '{-10'sd8, -10'sd13, -10'sd17, 10'sd15,  10'sd160, 10'sd283}
  };

  typedef logic [WIN-1:0][PIX_W-1:0] column_t;

  typedef struct packed {
    logic             emit;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } tag_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             white;
  } result_t;

endpackage

// ----- src/dog_edge_lines.sv -----
module dog_edge_lines
  import dog_edge_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              acc,
  input  logic [PIX_W-1:0]  pixel,
  input  logic              frame_start,
  input  logic [SIZE_W-1:0] frame_width,
  input  logic [SIZE_W-1:0] frame_height,
  output logic              col_valid,
  output column_t           col,
  output tag_t              col_tag
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SW = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
  localparam int HW = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;
  localparam int CX = (CW > POS_W) ? CW : POS_W;
  localparam int RX = (RW > POS_W) ? RW : POS_W;
  localparam int LB = LINES * PIX_W;

  logic [CW-1:0] col_r, col_nxt, c_base, c_cur, addr1_r;
  logic [RW-1:0] row_r, row_nxt, r_base, r_cur;
  logic [SW-1:0] fw_ext, w_eff;
  logic [HW-1:0] fh_ext, h_eff;
  logic [CX-1:0] cdiff;
  logic [RX-1:0] rdiff;
  tag_t          tag0, tag1_r;
  logic          v1_r, fwd_r;
  logic [PIX_W-1:0] pix1_r;
  logic [LB-1:0] rdata_r, last_r, rd_word, wword;

  logic [LB-1:0] mem [MAX_WIDTH];

  always_comb begin
    fw_ext = SW'(frame_width);
    fh_ext = HW'(frame_height);
    if (fw_ext > SW'(MAX_WIDTH)) w_eff = SW'(MAX_WIDTH);
    else if (fw_ext == '0)       w_eff = SW'(1);
    else                         w_eff = fw_ext;
    if (fh_ext > HW'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else if (fh_ext == '0)        h_eff = HW'(1);
    else                          h_eff = fh_ext;

    c_base = frame_start ? '0 : col_r;
    r_base = frame_start ? '0 : row_r;
    c_cur  = (SW'(c_base) >= w_eff) ? '0 : c_base;
    r_cur  = (HW'(r_base) >= h_eff) ? '0 : r_base;

    if (SW'(c_cur) + SW'(1) >= w_eff) begin
      col_nxt = '0;
      row_nxt = (HW'(r_cur) + HW'(1) >= h_eff) ? '0 : r_cur + RW'(1);
    end else begin
      col_nxt = c_cur + CW'(1);
      row_nxt = r_cur;
    end

    cdiff = CX'(c_cur) - CX'(HALF);
    rdiff = RX'(r_cur) - RX'(HALF);
    tag0.emit = (CX'(c_cur) >= CX'(WIN - 1)) && (RX'(r_cur) >= RX'(WIN - 1));
    tag0.row  = rdiff[POS_W-1:0];
    tag0.col  = cdiff[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      v1_r  <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      v1_r <= acc;
      if (acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        // The column written back this cycle is the one being read.
        fwd_r <= v1_r && (c_cur == addr1_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rdata_r <= mem[c_cur];
      addr1_r <= c_cur;
      pix1_r  <= pixel;
      tag1_r  <= tag0;
    end
    if (v1_r) begin
      mem[addr1_r] <= wword;
      last_r       <= wword;
    end
  end

  always_comb begin
    rd_word = fwd_r ? last_r : rdata_r;
    for (int k = 0; k < LINES; k++) begin
      col[k] = rd_word[k*PIX_W +: PIX_W];
    end
    col[LINES] = pix1_r;
    for (int k = 0; k < LINES; k++) begin
      wword[k*PIX_W +: PIX_W] = col[k+1];
    end
  end

  assign col_valid = v1_r;
  assign col_tag   = tag1_r;

endmodule

// ----- src/dog_edge_conv.sv -----
module dog_edge_conv
  import dog_edge_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    col_valid,
  input  column_t                 col,
  input  tag_t                    col_tag,
  input  logic signed [SUM_W-1:0] threshold,
  output logic [1:0]              pend_cnt,
  output logic                    res_valid,
  output result_t                 res
);

  logic [PIX_W-1:0]  win_r [WIN][WIN];
  logic [FOLD_W-1:0] fold, fold_r [QUAD][QUAD];
  logic signed [SUM_W-1:0] psum [QUAD];
  logic signed [SUM_W-1:0] psum_r [QUAD];
  logic signed [SUM_W-1:0] total, total_r;
  logic va_r, vb_r, vc_r;
  tag_t ta_r, tb_r, tc_r;
  logic [FOLD_W-1:0] fold_c [QUAD][QUAD];

  always_ff @(posedge clk) begin
    if (col_valid) begin
      for (int y = 0; y < WIN; y++) begin
        for (int x = 0; x < WIN - 1; x++) begin
          win_r[y][x] <= win_r[y][x+1];
        end
        win_r[y][WIN-1] <= col[y];
      end
    end
  end

  // Mirror-fold the window so each kernel value multiplies once.
  always_comb begin
    for (int i = 0; i < QUAD; i++) begin
      for (int j = 0; j < QUAD; j++) begin
        fold = FOLD_W'(win_r[i][j]);
        if (j < HALF) fold = fold + FOLD_W'(win_r[i][WIN-1-j]);
        if (i < HALF) begin
          fold = fold + FOLD_W'(win_r[WIN-1-i][j]);
          if (j < HALF) fold = fold + FOLD_W'(win_r[WIN-1-i][WIN-1-j]);
        end
        fold_c[i][j] = fold;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < QUAD; i++) begin
      psum[i] = '0;
      for (int j = 0; j < QUAD; j++) begin
        psum[i] = psum[i] + $signed(SUM_W'({1'b0, fold_r[i][j]})) * SUM_W'(KQ[i][j]);
      end
    end
    total = '0;
    for (int i = 0; i < QUAD; i++) begin
      total = total + psum_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      vc_r      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      va_r      <= col_valid && col_tag.emit;
      vb_r      <= va_r;
      vc_r      <= vb_r;
      res_valid <= vc_r;
    end
  end

  // The window register is read in the cycle after the column that completes it.
  tag_t ts_r;

  always_ff @(posedge clk) begin
    ts_r <= col_tag;
    if (va_r) begin
      fold_r <= fold_c;
      ta_r   <= ts_r;
    end
    if (vb_r) begin
      psum_r <= psum;
      tb_r   <= ta_r;
    end
    if (vc_r) begin
      total_r <= total;
      tc_r    <= tb_r;
    end
  end

  assign res.row   = tc_r.row;
  assign res.col   = tc_r.col;
  assign res.white = (total_r >= threshold);
  assign pend_cnt  = 2'(va_r) + 2'(vb_r) + 2'(vc_r);

endmodule

// ----- src/dog_edge_ofifo.sv -----
module dog_edge_ofifo
  import dog_edge_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  result_t                  din,
  input  logic                     pop,
  output logic                     not_empty,
  output result_t                  dout,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int AW = $clog2(DEPTH);

  result_t       mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  assign not_empty = (cnt_r != '0);
  assign dout      = mem_r[rp_r];
  assign count     = cnt_r;

endmodule

// ----- src/dog_edge_threshold_11x11.sv -----
// 11x11 difference-of-Gaussian edge threshold over a raster pixel stream.
// Input channel: one 8-bit grey pixel per transfer, in raster order;
// in_frame_start marks row 0, column 0 of a frame. Output channel: one
// transfer per interior pixel (row and column at least 5 from the top-left
// and fully covered by the window), with its row, column and a white flag
// set when the kernel sum is at or above the threshold. Border pixels are
// never sent. Configuration (threshold, frame width, frame height) is written
// through cfg_we / cfg_index / cfg_wdata; the user must do this only while
// the block is idle, which the block does not enforce. Throughput is one
// pixel per clock while in_stall is low. A result passes the line-store read,
// window shift, mirror fold, row partial sums, final sum and output queue.
// The line store is one memory of MAX_WIDTH words of ten pixels, read and
// written once per pixel; back-to-back accesses to the same column are
// forwarded. Results wait in an 8-entry queue; when the receiver stalls, the
// input keeps flowing until the queue plus results in flight fill it, then
// in_stall rises. Reset clears the counters, the queue and the pipeline;
// the line store and window contents are not cleared.
module dog_edge_threshold_11x11
  import dog_edge_pkg::*;
#(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [PIX_W-1:0]   in_pixel_value,
  input  logic               in_frame_start,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [POS_W-1:0]   out_centre_row,
  output logic [POS_W-1:0]   out_centre_col,
  output logic               out_edge_white,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [SUM_W-1:0]   cfg_wdata
);

  localparam int QDEPTH = 8;
  localparam int QCW    = $clog2(QDEPTH) + 1;

  logic signed [SUM_W-1:0] threshold_r;
  logic [SIZE_W-1:0]       frame_width_r, frame_height_r;
  logic                    acc, col_valid, res_valid, q_not_empty;
  column_t                 col;
  tag_t                    col_tag;
  result_t                 res, q_out;
  logic [1:0]              pend_cnt;
  logic [QCW-1:0]          q_count, occupied;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r    <= SUM_W'(1);
      frame_width_r  <= SIZE_W'(512);
      frame_height_r <= SIZE_W'(512);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:    threshold_r    <= cfg_wdata;
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Every result that may still arrive holds a queue slot.
  assign occupied = q_count + QCW'(col_valid & col_tag.emit) + QCW'(pend_cnt)
                  + QCW'(res_valid);
  assign in_stall = (occupied >= QCW'(QDEPTH));
  assign acc      = in_valid && !in_stall;

  dog_edge_lines #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_lines (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (acc),
    .pixel        (in_pixel_value),
    .frame_start  (in_frame_start),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .col_valid    (col_valid),
    .col          (col),
    .col_tag      (col_tag)
  );

  dog_edge_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .col_valid (col_valid),
    .col       (col),
    .col_tag   (col_tag),
    .threshold (threshold_r),
    .pend_cnt  (pend_cnt),
    .res_valid (res_valid),
    .res       (res)
  );

  dog_edge_ofifo #(
    .DEPTH (QDEPTH)
  ) u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .din       (res),
    .pop       (q_not_empty && !out_stall),
    .not_empty (q_not_empty),
    .dout      (q_out),
    .count     (q_count)
  );

  assign out_valid      = q_not_empty;
  assign out_centre_row = q_out.row;
  assign out_centre_col = q_out.col;
  assign out_edge_white = q_out.white;

endmodule

// ----- src/dog_edge_threshold_11x11_chk.sv -----
`include "dog_edge_threshold_11x11_assert.svh"

module dog_edge_threshold_11x11_chk
  import dog_edge_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [PIX_W-1:0]   in_pixel_value,
  input logic               in_frame_start,
  input logic               out_valid,
  input logic               out_stall,
  input logic [POS_W-1:0]   out_centre_row,
  input logic [POS_W-1:0]   out_centre_col,
  input logic               out_edge_white,
  input logic               cfg_we,
  input logic [IDX_W-1:0]   cfg_index,
  input logic [SUM_W-1:0]   cfg_wdata
);

  `DOG_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")

  `DOG_ASSERT_RST(a_rst_quiet, !rst_n |=> !out_valid, "result shown right after reset")

  `DOG_ASSERT(a_interior, out_valid |-> out_centre_row >= POS_W'(HALF) && out_centre_col >= POS_W'(HALF), "border pixel sent")

endmodule

bind dog_edge_threshold_11x11 dog_edge_threshold_11x11_chk u_chk (.*);

// ----- dv/dog_edge_checker.sv -----
`timescale 1ns / 1ps

module dog_edge_checker
  import dog_edge_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [PIX_W-1:0] in_pixel_value,
  input  logic             in_frame_start,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [POS_W-1:0] out_centre_row,
  input  logic [POS_W-1:0] out_centre_col,
  input  logic             out_edge_white,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [SUM_W-1:0] cfg_wdata,
  output int               fails,
  output int               pending
);

  localparam int MAX_W = 512;
  localparam int MAX_H = 512;

  int                      kern [WIN][WIN];
  logic [PIX_W-1:0]        line_mem [LINES][MAX_W];
  logic [PIX_W-1:0]        win_pix [WIN][WIN];
  int                      col_pos;
  int                      row_pos;
  logic signed [SUM_W-1:0] thr;
  int                      width_reg;
  int                      height_reg;
  result_t                 centre_q [$];

  // The package holds one quadrant; mirror it on both axes.
  initial begin
    for (int y = 0; y < WIN; y++) begin
      for (int x = 0; x < WIN; x++) begin
        kern[y][x] = KQ[(y <= HALF) ? y : WIN - 1 - y][(x <= HALF) ? x : WIN - 1 - x];
      end
    end
  end

  task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic start);
    int               w;
    int               h;
    int               c;
    int               r;
    int               acc;
    logic [PIX_W-1:0] column [WIN];
    result_t          res;
    w = (width_reg > MAX_W) ? MAX_W : ((width_reg < 1) ? 1 : width_reg);
    h = (height_reg > MAX_H) ? MAX_H : ((height_reg < 1) ? 1 : height_reg);
    if (start) begin
      col_pos = 0;
      row_pos = 0;
    end
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    r = row_pos;
    for (int k = 0; k < LINES; k++) column[k] = line_mem[k][c];
    column[LINES] = pix;
    for (int k = 0; k < LINES; k++) line_mem[k][c] = column[k + 1];
    for (int y = 0; y < WIN; y++) begin
      for (int x = 0; x < WIN - 1; x++) win_pix[y][x] = win_pix[y][x + 1];
      win_pix[y][WIN - 1] = column[y];
    end
    if (r >= WIN - 1 && c >= WIN - 1) begin
      acc = 0;
      for (int y = 0; y < WIN; y++) begin
        for (int x = 0; x < WIN; x++) acc += kern[y][x] * int'(win_pix[y][x]);
      end
      res.row   = POS_W'(r - HALF);
      res.col   = POS_W'(c - HALF);
      res.white = (acc >= int'(thr));
      centre_q.push_back(res);
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      thr        = 1;
      width_reg  = 512;
      height_reg = 512;
      col_pos    = 0;
      row_pos    = 0;
      centre_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD:    thr = cfg_wdata;
          REG_FRAME_WIDTH:  width_reg = int'(cfg_wdata[SIZE_W-1:0]);
          REG_FRAME_HEIGHT: height_reg = int'(cfg_wdata[SIZE_W-1:0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_pixel(in_pixel_value, in_frame_start);
      if (out_valid && !out_stall) begin
        if (centre_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result row %0d col %0d white %0b", $time,
                   out_centre_row, out_centre_col, out_edge_white);
        end else begin
          want = centre_q.pop_front();
          if (want.row !== out_centre_row) begin
            fails++;
            $display("%0t: centre_row expected %0d actual %0d", $time, want.row,
                     out_centre_row);
          end
          if (want.col !== out_centre_col) begin
            fails++;
            $display("%0t: centre_col expected %0d actual %0d", $time, want.col,
                     out_centre_col);
          end
          if (want.white !== out_edge_white) begin
            fails++;
            $display("%0t: edge_white at (%0d,%0d) expected %0b actual %0b", $time,
                     want.row, want.col, want.white, out_edge_white);
          end
        end
      end
    end
    pending <= centre_q.size();
  end

  initial fails = 0;

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import dog_edge_pkg::*;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [PIX_W-1:0] in_pixel_value;
  logic             in_frame_start;
  logic             out_valid;
  logic             out_stall;
  logic [POS_W-1:0] out_centre_row;
  logic [POS_W-1:0] out_centre_col;
  logic             out_edge_white;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [SUM_W-1:0] cfg_wdata;
  int               fails;
  int               pending;

  bit               no_gaps;
  bit               hold_go;
  int               pixels_sent;

  dog_edge_threshold_11x11 DUT (.*);

  dog_edge_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off that backs up the block.
  // The hold-off starts at the first result shown after it is armed.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_go && out_valid) begin
        hold_go   = 0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= no_gaps ? 1'b0 : ($urandom_range(99) < 30);
      end
    end
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic start);
    in_pixel_value <= pix;
    in_frame_start <= start;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    if (!no_gaps && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // Configuration goes in only once all results are out and the pipeline is empty.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [SUM_W-1:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(input int w, input int h, input logic [SUM_W-1:0] t);
    write_reg(REG_FRAME_WIDTH, SUM_W'(w));
    write_reg(REG_FRAME_HEIGHT, SUM_W'(h));
    write_reg(REG_THRESHOLD, t);
  endtask

  // Pattern: 0 uniform random, 1 smooth, 2 black/white, 3 constant, 4 checkerboard.
  task automatic send_frame(input int w, input int h, input int pattern,
                            input logic [PIX_W-1:0] level, input bit noise);
    logic [PIX_W-1:0] pix;
    int               base;
    base = $urandom_range(255);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        case (pattern)
          0: pix = PIX_W'($urandom_range(255));
          1: pix = PIX_W'((base + $urandom_range(40)) > 255 ? 255 : base + $urandom_range(40));
          2: pix = $urandom_range(1) ? 8'hFF : 8'h00;
          3: pix = level;
          default: pix = ((r + c) % 2) ? 8'hFF : 8'h00;
        endcase
        // A stray frame start in mid-frame restarts the counters.
        if (noise && $urandom_range(99) == 0) begin
          send_pixel(pix, 1'b1);
          return;
        end
        send_pixel(pix, (r == 0 && c == 0));
      end
    end
  endtask

  initial begin
    int w;
    int h;
    int phase;
    logic [SUM_W-1:0] t;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_pixel_value <= '0;
    in_frame_start <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_THRESHOLD;
    cfg_wdata      <= '0;
    no_gaps     = 0;
    hold_go     = 0;
    pixels_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes: a short run of pixel extremes that cannot reach a result.
    send_pixel(8'h00, 1'b1);
    send_pixel(8'hFF, 1'b0);
    send_pixel(8'h80, 1'b0);
    send_pixel(8'h7F, 1'b0);
    send_pixel(8'h55, 1'b1);
    send_pixel(8'hAA, 1'b0);

    // Smallest frame, one result each, at the threshold extremes.
    set_frame(11, 11, 24'd0);
    send_frame(11, 11, 3, 8'hFF, 0);
    send_frame(11, 11, 3, 8'h00, 0);
    write_reg(REG_THRESHOLD, 24'h7FFFFF);
    send_frame(11, 11, 4, 8'h00, 0);
    send_frame(11, 11, 3, 8'h00, 0);
    write_reg(REG_THRESHOLD, 24'h800000);
    send_frame(11, 11, 3, 8'hFF, 0);
    send_frame(11, 11, 0, 8'h00, 0);

    // A wider row, smallest height, with no idling on either side.
    set_frame(40, 11, 24'd1);
    no_gaps = 1;
    send_frame(40, 11, 2, 8'h00, 0);
    no_gaps = 0;

    phase = 0;
    while (pixels_sent < 1800) begin
      if (phase == 0) begin
        w = 24;
        h = 18;
      end else begin
        w = $urandom_range(11, 24);
        h = $urandom_range(11, 18);
      end
      case ($urandom_range(9))
        0: t = 24'h7FFFFF;
        1: t = 24'h800000;
        2: t = 24'(-$urandom_range(60000));
        default: t = 24'($urandom_range(40000) - 20000);
      endcase
      set_frame(w, h, t);
      if (phase == 0) hold_go = 1;
      send_frame(w, h, $urandom_range(4), PIX_W'($urandom()),
                 (phase != 0) && ($urandom_range(3) == 0));
      // A second frame follows straight after the first; it also begins with a frame start.
      if ($urandom_range(1)) begin
        send_frame(w, h, $urandom_range(3), PIX_W'($urandom()), 0);
      end
      phase++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fails == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule
